// ===== design/clcd_pkg.sv =====
package clcd_pkg;

	// Task operation codes.
	localparam logic [2:0] OP_WAIT    = 3'd0;
	localparam logic [2:0] OP_CMD_WR  = 3'd1;
	localparam logic [2:0] OP_CMD_RD  = 3'd2;
	localparam logic [2:0] OP_DATA_WR = 3'd3;
	localparam logic [2:0] OP_DATA_RD = 3'd4;

	// Pin sequencer phases.
	localparam logic [3:0] PH_SETUP     = 4'd0;
	localparam logic [3:0] PH_HI_DRIVE  = 4'd1;
	localparam logic [3:0] PH_HI_EUP    = 4'd2;
	localparam logic [3:0] PH_HI_SAMPLE = 4'd3;
	localparam logic [3:0] PH_HI_EDOWN  = 4'd4;
	localparam logic [3:0] PH_LO_DRIVE  = 4'd5;
	localparam logic [3:0] PH_LO_EUP    = 4'd6;
	localparam logic [3:0] PH_LO_SAMPLE = 4'd7;
	localparam logic [3:0] PH_LO_EDOWN  = 4'd8;

	// Request type codes.
	localparam logic REQ_ENQUEUE = 1'b0;

	// One input request.
	typedef struct packed {
		logic       req_type;
		logic [2:0] task_op;
		logic [7:0] task_byte;
		logic [1:0] bus_mode;
		logic [3:0] pins_in;
	} in_item_t;

	// One result.
	typedef struct packed {
		logic       rs_pin;
		logic       rw_pin;
		logic       en_pin;
		logic [3:0] nibble_out;
		logic       bus_is_input;
		logic       read_done;
		logic [7:0] read_byte;
		logic       dropped;
		logic       idle;
	} out_item_t;

	// One queued task.
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
		logic [2:0] op;
	} task_t;

	// Queue control from the sequencer.
	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	// Queue status toward the sequencer.
	typedef struct packed {
		logic empty;
		logic one;
		logic full;
	} q_stat_t;

	function automatic logic is_write(input logic [2:0] op);
		return (op == OP_CMD_WR) || (op == OP_DATA_WR);
	endfunction

endpackage

// ===== design/clcd_queue.sv =====
module clcd_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  clcd_pkg::q_ctrl_t ctrl,
	input  clcd_pkg::task_t  wr_task,
	output clcd_pkg::task_t  head_task,
	output clcd_pkg::q_stat_t stat
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	clcd_pkg::task_t mem [QUEUE_DEPTH];
	clcd_pkg::task_t head_q;
	logic [PW-1:0] head_ptr_q, tail_ptr_q, head_ptr_d, tail_ptr_d;
	logic [CW-1:0] count_q, count_d;

	// Next pointer and count values.
	always_comb begin
		head_ptr_d = head_ptr_q;
		tail_ptr_d = tail_ptr_q;
		count_d = count_q;
		if (ctrl.pop) begin
			head_ptr_d = (head_ptr_q == LAST_PTR) ? '0 : head_ptr_q + 1'b1;
		end
		if (ctrl.push) begin
			tail_ptr_d = (tail_ptr_q == LAST_PTR) ? '0 : tail_ptr_q + 1'b1;
		end
		unique case ({ctrl.push, ctrl.pop})
			2'b10: count_d = count_q + 1'b1;
			2'b01: count_d = count_q - 1'b1;
			default: count_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ptr_q <= '0;
			tail_ptr_q <= '0;
			count_q <= '0;
		end else begin
			head_ptr_q <= head_ptr_d;
			tail_ptr_q <= tail_ptr_d;
			count_q <= count_d;
		end
	end

	// Storage; the read port always fetches the entry at the next head,
	// with a bypass when that entry is being written in the same cycle.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail_ptr_q] <= wr_task;
		end
		if (ctrl.push && (tail_ptr_q == head_ptr_d)) begin
			head_q <= wr_task;
		end else begin
			head_q <= mem[head_ptr_d];
		end
	end

	assign head_task = head_q;
	assign stat.empty = (count_q == '0);
	assign stat.one = (count_q == CW'(1));
	assign stat.full = (count_q == FULL_CNT);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> !stat.empty)
		else $error("pop from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |-> !stat.full)
		else $error("push into full queue");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.pop && !ctrl.push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop did not lower the count");

endmodule

// ===== design/clcd_seq.sv =====
module clcd_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  clcd_pkg::in_item_t item,
	input  clcd_pkg::task_t    head_task,
	input  clcd_pkg::q_stat_t  stat,
	output clcd_pkg::q_ctrl_t  ctrl,
	output clcd_pkg::task_t    wr_task,
	output clcd_pkg::out_item_t result
);

	logic            pend_valid_q, pv_d;
	clcd_pkg::task_t pend_q, pt_d;
	logic [2:0]      act_op_q, op_d;
	logic            act_8bit_q, m8_d;
	logic [7:0]      shift_q, sh_d;
	logic [3:0]      phase_q, ph_d;
	logic            busy_q, busy_d;
	logic            rs_q, rs_d, rw_q, rw_d, en_q, en_d, bus_in_q, bus_in_d;
	logic [3:0]      nib_q, nib_d;
	logic            push, pop, dropped, rdone, busy_now, take, empty_next;
	logic [7:0]      rbyte;

	// One request: queue a task, or move the pin sequence one phase.
	always_comb begin
		pv_d = pend_valid_q;
		pt_d = pend_q;
		op_d = act_op_q;
		m8_d = act_8bit_q;
		sh_d = shift_q;
		ph_d = phase_q;
		busy_d = busy_q;
		rs_d = rs_q;
		rw_d = rw_q;
		en_d = en_q;
		nib_d = nib_q;
		bus_in_d = bus_in_q;
		push = 1'b0;
		pop = 1'b0;
		dropped = 1'b0;
		rdone = 1'b0;
		rbyte = '0;
		busy_now = busy_q;
		take = 1'b0;
		wr_task.op = (item.task_op > clcd_pkg::OP_DATA_RD) ? clcd_pkg::OP_WAIT : item.task_op;
		wr_task.data_byte = item.task_byte;
		wr_task.mode = item.bus_mode;

		if (item.req_type == clcd_pkg::REQ_ENQUEUE) begin
			if (stat.full) begin
				dropped = 1'b1;
			end else begin
				push = 1'b1;
			end
		end else begin
			unique case (phase_q)
				clcd_pkg::PH_SETUP: begin
					// A finished status read leaves its busy flag.
					if (act_op_q == clcd_pkg::OP_CMD_RD) begin
						busy_now = shift_q[7];
					end
					busy_d = busy_now;
					take = !pend_valid_q ||
						((pend_q.op == act_op_q) && (pend_q.op != clcd_pkg::OP_WAIT));
					if (take) begin
						if (stat.empty) begin
							pv_d = 1'b0;
						end else begin
							pv_d = 1'b1;
							pt_d = head_task;
							pop = 1'b1;
						end
					end
					// Choose what the next bus cycle does.
					if (!pv_d) begin
						op_d = clcd_pkg::OP_WAIT;
					end else if (pt_d.op == clcd_pkg::OP_WAIT) begin
						op_d = clcd_pkg::OP_WAIT;
						if (pt_d.data_byte != 8'd0) begin
							pt_d.data_byte = pt_d.data_byte - 8'd1;
						end else begin
							pv_d = 1'b0;
						end
					end else if (!pt_d.mode[1] && busy_now) begin
						op_d = clcd_pkg::OP_CMD_RD;
						m8_d = pt_d.mode[0];
					end else begin
						if (!pt_d.mode[1]) begin
							busy_d = 1'b1;
						end
						op_d = pt_d.op;
						m8_d = pt_d.mode[0];
						sh_d = pt_d.data_byte;
					end
					// Set up RS and RW for a real bus cycle.
					if (op_d != clcd_pkg::OP_WAIT) begin
						rs_d = (op_d == clcd_pkg::OP_DATA_WR) || (op_d == clcd_pkg::OP_DATA_RD);
						rw_d = !clcd_pkg::is_write(op_d);
						if (clcd_pkg::is_write(op_d)) begin
							ph_d = clcd_pkg::PH_HI_DRIVE;
						end else begin
							sh_d = '0;
							ph_d = clcd_pkg::PH_HI_EUP;
						end
					end
				end
				clcd_pkg::PH_HI_DRIVE: begin
					nib_d = shift_q[7:4];
					ph_d = act_8bit_q ? clcd_pkg::PH_LO_EUP : clcd_pkg::PH_HI_EUP;
				end
				clcd_pkg::PH_HI_EUP: begin
					en_d = 1'b1;
					ph_d = clcd_pkg::is_write(act_op_q) ? clcd_pkg::PH_HI_EDOWN
						: clcd_pkg::PH_HI_SAMPLE;
				end
				clcd_pkg::PH_HI_SAMPLE: begin
					bus_in_d = 1'b1;
					sh_d = shift_q | {item.pins_in, 4'h0};
					if (act_8bit_q) begin
						bus_in_d = 1'b0;
						nib_d = '0;
						ph_d = clcd_pkg::PH_LO_EDOWN;
					end else begin
						ph_d = clcd_pkg::PH_HI_EDOWN;
					end
				end
				clcd_pkg::PH_HI_EDOWN: begin
					en_d = 1'b0;
					ph_d = clcd_pkg::is_write(act_op_q) ? clcd_pkg::PH_LO_DRIVE
						: clcd_pkg::PH_LO_EUP;
				end
				clcd_pkg::PH_LO_DRIVE: begin
					nib_d = shift_q[3:0];
					ph_d = clcd_pkg::PH_LO_EUP;
				end
				clcd_pkg::PH_LO_EUP: begin
					en_d = 1'b1;
					ph_d = clcd_pkg::is_write(act_op_q) ? clcd_pkg::PH_LO_EDOWN
						: clcd_pkg::PH_LO_SAMPLE;
				end
				clcd_pkg::PH_LO_SAMPLE: begin
					sh_d = shift_q | {4'h0, item.pins_in};
					bus_in_d = 1'b0;
					nib_d = '0;
					ph_d = clcd_pkg::PH_LO_EDOWN;
				end
				clcd_pkg::PH_LO_EDOWN: begin
					en_d = 1'b0;
					ph_d = clcd_pkg::PH_SETUP;
					if ((act_op_q == clcd_pkg::OP_CMD_RD) || (act_op_q == clcd_pkg::OP_DATA_RD)) begin
						rdone = 1'b1;
						rbyte = shift_q;
					end
				end
				default: begin
					ph_d = clcd_pkg::PH_SETUP;
				end
			endcase
		end
	end

	// Queue occupancy after this request.
	assign empty_next = pop ? stat.one : (stat.empty && !push);

	assign ctrl.push = push && advance;
	assign ctrl.pop = pop && advance;

	assign result.rs_pin = rs_d;
	assign result.rw_pin = rw_d;
	assign result.en_pin = en_d;
	assign result.nibble_out = nib_d;
	assign result.bus_is_input = bus_in_d;
	assign result.read_done = rdone;
	assign result.read_byte = rbyte;
	assign result.dropped = dropped;
	assign result.idle = empty_next && !pv_d && (ph_d == clcd_pkg::PH_SETUP);

	// Sequencer state moves only when a request is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			act_op_q <= clcd_pkg::OP_WAIT;
			act_8bit_q <= 1'b0;
			shift_q <= '0;
			phase_q <= clcd_pkg::PH_SETUP;
			busy_q <= 1'b1;
			rs_q <= 1'b0;
			rw_q <= 1'b0;
			en_q <= 1'b0;
			nib_q <= '0;
			bus_in_q <= 1'b0;
		end else if (advance) begin
			pend_valid_q <= pv_d;
			act_op_q <= op_d;
			act_8bit_q <= m8_d;
			shift_q <= sh_d;
			phase_q <= ph_d;
			busy_q <= busy_d;
			rs_q <= rs_d;
			rw_q <= rw_d;
			en_q <= en_d;
			nib_q <= nib_d;
			bus_in_q <= bus_in_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pend_q <= pt_d;
		end
	end

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= clcd_pkg::PH_LO_EDOWN)
		else $error("sequencer phase out of range");

	a_pop_in_setup: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> (phase_q == clcd_pkg::PH_SETUP) && item.req_type)
		else $error("task fetched outside the set-up phase");

	a_read_end: assert property (@(posedge clk) disable iff (!arst_n)
		result.read_done |-> (phase_q == clcd_pkg::PH_LO_EDOWN) && !en_d)
		else $error("read completed outside the last enable fall");

endmodule

// ===== design/char_lcd_bus_sequencer.sv =====
// Output: a request's result is registered into out_data as the request leaves
// the input register, once the output register is free or being emptied.
// Throughput: one request per cycle unless out_ready stalls; each request is
// one pass of the sequencer logic between the input and output registers.
// Reset (arst_n low): empty queue, no pending task, set-up phase, all pins low,
// data bus driven. The queue storage itself is not cleared.
module char_lcd_bus_sequencer #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  clcd_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output clcd_pkg::out_item_t out_data
);

	clcd_pkg::in_item_t  item_s1;
	logic                valid_s1;
	logic                advance;
	clcd_pkg::out_item_t result;
	clcd_pkg::out_item_t out_q;
	logic                out_valid_q;
	clcd_pkg::q_ctrl_t   q_ctrl;
	clcd_pkg::q_stat_t   q_stat;
	clcd_pkg::task_t     wr_task;
	clcd_pkg::task_t     head_task;

	// Stage 1 moves on when the output register is free or being emptied.
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	clcd_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (q_ctrl),
		.wr_task  (wr_task),
		.head_task(head_task),
		.stat     (q_stat)
	);

	clcd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item     (item_s1),
		.head_task(head_task),
		.stat     (q_stat),
		.ctrl     (q_ctrl),
		.wr_task  (wr_task),
		.result   (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("request lost in stage 1");

	a_advance_room: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed request produced no result");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !advance)
		else $error("stage 1 advanced into a full output register");

endmodule
